/* design/fbsg_pkg.sv */
// Types and constants shared by the FAT boot sector geometry decoder.
package fbsg_pkg;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_SECTOR_SIZE = 4'd1,
        ST_CLUSTER     = 4'd2,
        ST_FAT_COUNT   = 4'd3,
        ST_FAT_SIZE    = 4'd4,
        ST_RESERVED    = 4'd5,
        ST_VOL_SMALL   = 4'd6,
        ST_FAT12_LARGE = 4'd7,
        ST_FAT32_ROOT  = 4'd8,
        ST_NO_ROOT     = 4'd9,
        ST_BACKUP      = 4'd10
    } t_status;

    typedef enum logic [1:0] {
        FAT_NONE = 2'd0,
        FAT_12   = 2'd1,
        FAT_16   = 2'd2,
        FAT_32   = 2'd3
    } t_fat_type;

    localparam logic [3:0]  CFG_FORCED_TYPE = 4'd0;
    localparam logic [3:0]  CFG_BACKUP      = 4'd1;

    localparam logic [31:0] FAT12_LIMIT = 32'd4085;
    localparam logic [31:0] FAT16_LIMIT = 32'd65525;
    localparam logic [7:0]  MAX_FATS    = 8'd8;
    localparam logic [27:0] MASK12      = 28'h0000FFF;
    localparam logic [27:0] MASK16      = 28'h000FFFF;
    localparam logic [27:0] MASK32      = 28'hFFFFFFF;

    typedef struct packed {
        logic [15:0] bytes_per_sector;
        logic [7:0]  sectors_per_cluster;
        logic [7:0]  fat_copies;
        logic [15:0] root_entries;
        logic [15:0] total_sectors_short;
        logic [31:0] total_sectors_long;
        logic [15:0] fat_size_short;
        logic [31:0] fat_size_long;
        logic [15:0] reserved_sectors;
        logic [31:0] root_start_cluster;
    } t_bpb;

    typedef struct packed {
        t_status     status;
        t_fat_type   fat_type;
        logic [3:0]  sector_shift;
        logic [35:0] first_data_sector;
        logic [35:0] first_cluster_sector;
        logic [31:0] cluster_total;
        logic [32:0] last_cluster;
        logic [39:0] root_sector;
        logic [27:0] cluster_mask;
        logic [31:0] volume_sectors;
    } t_geom;

endpackage

/* design/fbsg_calc.sv */
// Combinational check and layout computation for one registered boot sector.
module fbsg_calc
    import fbsg_pkg::*;
(
    input  t_bpb       i_bpb,
    input  logic [1:0] i_forced_type,
    input  logic       i_backup,
    output t_geom      o_geom
);

    always_comb begin
        logic [31:0] vol;
        logic [31:0] fatsz;
        logic [3:0]  sh;
        logic [2:0]  csh;
        logic        sec_ok;
        logic        clus_ok;
        logic [35:0] fat_area;
        logic [35:0] dsect;
        logic [21:0] root_bytes;
        logic [12:0] root_secs;
        logic [35:0] csect;
        logic [31:0] ccount;
        logic [39:0] rclust_m2;
        logic [39:0] rsect;
        t_fat_type   ftype;
        t_status     st;
        logic [27:0] mask;

        vol   = (i_bpb.total_sectors_short != 16'd0) ? {16'd0, i_bpb.total_sectors_short}
                                                     : i_bpb.total_sectors_long;
        fatsz = (i_bpb.fat_size_short != 16'd0) ? {16'd0, i_bpb.fat_size_short}
                                                : i_bpb.fat_size_long;

        sec_ok = 1'b1;
        case (i_bpb.bytes_per_sector)
            16'd512:  sh = 4'd9;
            16'd1024: sh = 4'd10;
            16'd2048: sh = 4'd11;
            16'd4096: sh = 4'd12;
            default: begin
                sh     = 4'd0;
                sec_ok = 1'b0;
            end
        endcase

        clus_ok = 1'b1;
        case (i_bpb.sectors_per_cluster)
            8'd1:   csh = 3'd0;
            8'd2:   csh = 3'd1;
            8'd4:   csh = 3'd2;
            8'd8:   csh = 3'd3;
            8'd16:  csh = 3'd4;
            8'd32:  csh = 3'd5;
            8'd64:  csh = 3'd6;
            8'd128: csh = 3'd7;
            default: begin
                csh     = 3'd0;
                clus_ok = 1'b0;
            end
        endcase

        // At most eight copies, so the product is a sum of four shifted terms.
        fat_area = (i_bpb.fat_copies[0] ? {4'd0, fatsz}        : 36'd0)
                 + (i_bpb.fat_copies[1] ? {3'd0, fatsz, 1'b0}  : 36'd0)
                 + (i_bpb.fat_copies[2] ? {2'd0, fatsz, 2'b0}  : 36'd0)
                 + (i_bpb.fat_copies[3] ? {1'd0, fatsz, 3'b0}  : 36'd0);
        dsect = {20'd0, i_bpb.reserved_sectors} + fat_area;

        root_bytes = {1'b0, i_bpb.root_entries, 5'd0} + {6'd0, i_bpb.bytes_per_sector}
                   - 22'd1;
        root_secs  = 13'(root_bytes >> sh);
        csect      = dsect + {23'd0, root_secs};
        ccount     = (vol - csect[31:0]) >> csh;

        rclust_m2 = {8'd0, i_bpb.root_start_cluster} - 40'd2;
        rsect     = {4'd0, csect} + (rclust_m2 << csh);

        ftype = FAT_NONE;
        st    = ST_OK;
        if (!sec_ok) begin
            st = ST_SECTOR_SIZE;
        end else if (!clus_ok) begin
            st = ST_CLUSTER;
        end else if (i_bpb.fat_copies == 8'd0 || i_bpb.fat_copies > MAX_FATS) begin
            st = ST_FAT_COUNT;
        end else if (fatsz == 32'd0) begin
            st = ST_FAT_SIZE;
        end else if (i_bpb.reserved_sectors == 16'd0
                     || {16'd0, i_bpb.reserved_sectors} > vol) begin
            st = ST_RESERVED;
        end else if (csect > {4'd0, vol}) begin
            st = ST_VOL_SMALL;
        end else begin
            if (i_forced_type == 2'd0) begin
                if (ccount < FAT12_LIMIT) begin
                    ftype = FAT_12;
                end else if (ccount < FAT16_LIMIT) begin
                    ftype = FAT_16;
                end else begin
                    ftype = FAT_32;
                end
            end else begin
                ftype = t_fat_type'(i_forced_type);
            end
            if (ftype == FAT_12 && ccount >= FAT12_LIMIT) begin
                st = ST_FAT12_LARGE;
            end else if (ftype == FAT_32 && i_bpb.root_entries != 16'd0) begin
                st = ST_FAT32_ROOT;
            end else if (ftype != FAT_32 && i_bpb.root_entries == 16'd0) begin
                st = ST_NO_ROOT;
            end else if (i_backup && ftype != FAT_32) begin
                st = ST_BACKUP;
            end
        end

        case (ftype)
            FAT_12:  mask = MASK12;
            FAT_16:  mask = MASK16;
            default: mask = MASK32;
        endcase

        if (st == ST_OK) begin
            o_geom.status               = ST_OK;
            o_geom.fat_type             = ftype;
            o_geom.sector_shift         = sh;
            o_geom.first_data_sector    = dsect;
            o_geom.first_cluster_sector = csect;
            o_geom.cluster_total        = ccount;
            o_geom.last_cluster         = {1'b0, ccount} + 33'd1;
            o_geom.root_sector          = (ftype == FAT_32) ? rsect : {4'd0, dsect};
            o_geom.cluster_mask         = mask;
            o_geom.volume_sectors       = vol;
        end else begin
            o_geom        = '0;
            o_geom.status = st;
        end
    end

endmodule

/* design/fat_boot_sector_geometry_decoder.sv */
// Top level of the FAT boot sector geometry decoder: handshakes, registers, checks.
//
// Each input transaction carries the numeric fields of one FAT boot sector.
// The block validates them and returns one result transaction per input with
// a status code, the detected or requested FAT type and the volume layout.
// Both data channels use valid and stall; a transaction completes on a clock
// edge where valid is high and stall is low. Configuration is written over a
// separate valid/ready channel that is always ready: index 0 sets the forced
// FAT type, index 1 marks the sector as the backup copy; other indices are
// ignored. Configuration should only change while no transaction is in flight.
// The result is registered: the input register feeds the check and layout logic
// (one short shift-add for the FAT area and a few 36/40-bit adds and compares),
// which loads the result register once that register is free.
// Throughput is one transaction per cycle while the receiver does not stall. When the receiver
// stalls, the result register holds, the input register fills, and then o_in_stall rises.
// Synchronous reset clears both valid flags and the configuration registers.
module fat_boot_sector_geometry_decoder
    import fbsg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_bytes_per_sector,
    input  logic [7:0]  i_sectors_per_cluster,
    input  logic [7:0]  i_fat_copies,
    input  logic [15:0] i_root_entries,
    input  logic [15:0] i_total_sectors_short,
    input  logic [31:0] i_total_sectors_long,
    input  logic [15:0] i_fat_size_short,
    input  logic [31:0] i_fat_size_long,
    input  logic [15:0] i_reserved_sectors,
    input  logic [31:0] i_root_start_cluster,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_status,
    output logic [1:0]  o_fat_type,
    output logic [3:0]  o_sector_shift,
    output logic [35:0] o_first_data_sector,
    output logic [35:0] o_first_cluster_sector,
    output logic [31:0] o_cluster_total,
    output logic [32:0] o_last_cluster,
    output logic [39:0] o_root_sector,
    output logic [27:0] o_cluster_mask,
    output logic [31:0] o_volume_sectors,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic       r_in_valid;
    t_bpb       r_in;
    logic       r_out_valid;
    t_geom      r_out;
    logic [1:0] r_forced_type;
    logic       r_backup;
    t_geom      n_out;
    logic       out_free;
    logic       in_take;
    t_bpb       in_bpb;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !out_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign in_bpb.bytes_per_sector    = i_bytes_per_sector;
    assign in_bpb.sectors_per_cluster = i_sectors_per_cluster;
    assign in_bpb.fat_copies          = i_fat_copies;
    assign in_bpb.root_entries        = i_root_entries;
    assign in_bpb.total_sectors_short = i_total_sectors_short;
    assign in_bpb.total_sectors_long  = i_total_sectors_long;
    assign in_bpb.fat_size_short      = i_fat_size_short;
    assign in_bpb.fat_size_long       = i_fat_size_long;
    assign in_bpb.reserved_sectors    = i_reserved_sectors;
    assign in_bpb.root_start_cluster  = i_root_start_cluster;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forced_type <= 2'd0;
            r_backup      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_FORCED_TYPE) begin
                r_forced_type <= i_cfg_data[1:0];
            end else if (i_cfg_index == CFG_BACKUP) begin
                r_backup <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (in_take) begin
            r_in <= in_bpb;
        end
    end

    fbsg_calc u_calc (
        .i_bpb         (r_in),
        .i_forced_type (r_forced_type),
        .i_backup      (r_backup),
        .o_geom        (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (out_free && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_status               = r_out.status;
    assign o_fat_type             = r_out.fat_type;
    assign o_sector_shift         = r_out.sector_shift;
    assign o_first_data_sector    = r_out.first_data_sector;
    assign o_first_cluster_sector = r_out.first_cluster_sector;
    assign o_cluster_total        = r_out.cluster_total;
    assign o_last_cluster         = r_out.last_cluster;
    assign o_root_sector          = r_out.root_sector;
    assign o_cluster_mask         = r_out.cluster_mask;
    assign o_volume_sectors       = r_out.volume_sectors;

    a_item_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && out_free |=> r_out_valid)
        else $error("Registered transaction did not reach the result register.");

    a_error_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |->
            o_fat_type == FAT_NONE && o_first_data_sector == '0
            && o_cluster_total == '0 && o_root_sector == '0 && o_cluster_mask == '0)
        else $error("Failed check left layout fields non-zero.");

    a_ok_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OK |->
            o_fat_type != FAT_NONE && o_sector_shift >= 4'd9 && o_sector_shift <= 4'd12)
        else $error("Accepted boot sector has no type or a bad sector shift.");

    a_last_cluster: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OK |->
            o_last_cluster == {1'b0, o_cluster_total} + 33'd1)
        else $error("Last cluster does not follow the cluster count.");

    a_fat32_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OK && o_fat_type == FAT_32 |->
            o_cluster_mask == MASK32)
        else $error("FAT32 result carries the wrong cluster mask.");

endmodule

/* tb/fat_boot_sector_geometry_decoder_test.sv */
// Self-checking testbench for the FAT boot sector geometry decoder.
`timescale 1ns / 100ps

module fat_boot_sector_geometry_decoder_test;
    import fbsg_pkg::*;

    localparam logic [3:0] CFG_SPARE = 4'd9;
    localparam int DIR_ENTRY_BYTES = 32;
    localparam int PHASES = 8;
    localparam int RANDOM_PER_PHASE = 91;
    localparam int IDLE_PERCENT = 15;
    localparam int HOLD_CYCLES = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_bytes_per_sector = '0;
    logic [7:0]  i_sectors_per_cluster = '0;
    logic [7:0]  i_fat_copies = '0;
    logic [15:0] i_root_entries = '0;
    logic [15:0] i_total_sectors_short = '0;
    logic [31:0] i_total_sectors_long = '0;
    logic [15:0] i_fat_size_short = '0;
    logic [31:0] i_fat_size_long = '0;
    logic [15:0] i_reserved_sectors = '0;
    logic [31:0] i_root_start_cluster = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [3:0]  o_status;
    logic [1:0]  o_fat_type;
    logic [3:0]  o_sector_shift;
    logic [35:0] o_first_data_sector;
    logic [35:0] o_first_cluster_sector;
    logic [31:0] o_cluster_total;
    logic [32:0] o_last_cluster;
    logic [39:0] o_root_sector;
    logic [27:0] o_cluster_mask;
    logic [31:0] o_volume_sectors;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    t_bpb  boot_sectors_queued[$];
    t_geom geometry_due[$];
    t_bpb  offered;
    t_geom want_geom;
    logic [1:0] forced_mode = 2'd0;
    logic       backup_mode = 1'b0;
    logic       steady = 1'b0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int mismatches = 0;
    int results_checked = 0;
    int decoded_ok = 0;

    fat_boot_sector_geometry_decoder u_dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic t_geom decode_geometry(input t_bpb b, input logic [1:0] mode,
                                              input logic backup);
        t_geom g;
        t_status st;
        t_fat_type ty;
        logic [63:0] vol, fat_len, data_start, clus_start, clusters, root_at;
        int sh, csh, k;
        g = '0;
        st = ST_OK;
        ty = FAT_NONE;
        sh = 0;
        csh = -1;
        data_start = '0;
        clus_start = '0;
        clusters = '0;
        vol = (b.total_sectors_short != 16'd0) ? 64'(b.total_sectors_short)
                                               : 64'(b.total_sectors_long);
        fat_len = (b.fat_size_short != 16'd0) ? 64'(b.fat_size_short)
                                              : 64'(b.fat_size_long);
        case (b.bytes_per_sector)
            16'd512:  sh = 9;
            16'd1024: sh = 10;
            16'd2048: sh = 11;
            16'd4096: sh = 12;
            default:  st = ST_SECTOR_SIZE;
        endcase
        if (st == ST_OK) begin
            for (k = 0; k < 8; k++) begin
                if (b.sectors_per_cluster == 8'(1 << k)) csh = k;
            end
            if (csh < 0) st = ST_CLUSTER;
        end
        if (st == ST_OK && (b.fat_copies == 8'd0 || b.fat_copies > MAX_FATS))
            st = ST_FAT_COUNT;
        if (st == ST_OK && fat_len == 64'd0)
            st = ST_FAT_SIZE;
        if (st == ST_OK && (b.reserved_sectors == 16'd0 || 64'(b.reserved_sectors) > vol))
            st = ST_RESERVED;
        if (st == ST_OK) begin
            data_start = 64'(b.reserved_sectors) + fat_len * 64'(b.fat_copies);
            clus_start = data_start + ((64'(b.root_entries) * DIR_ENTRY_BYTES
                                        + 64'(b.bytes_per_sector) - 64'd1) >> sh);
            if (clus_start > vol) st = ST_VOL_SMALL;
            else clusters = (vol - clus_start) >> csh;
        end
        if (st == ST_OK) begin
            if (mode == FAT_NONE) begin
                if (clusters < 64'(FAT12_LIMIT)) ty = FAT_12;
                else if (clusters < 64'(FAT16_LIMIT)) ty = FAT_16;
                else ty = FAT_32;
            end else begin
                ty = t_fat_type'(mode);
                if (ty == FAT_12 && clusters >= 64'(FAT12_LIMIT)) st = ST_FAT12_LARGE;
            end
        end
        if (st == ST_OK && ty == FAT_32 && b.root_entries != 16'd0) st = ST_FAT32_ROOT;
        if (st == ST_OK && ty != FAT_32 && b.root_entries == 16'd0) st = ST_NO_ROOT;
        if (st == ST_OK && backup && ty != FAT_32) st = ST_BACKUP;
        if (st == ST_OK) begin
            if (ty == FAT_32)
                root_at = clus_start + ((64'(b.root_start_cluster) - 64'd2) << csh);
            else
                root_at = data_start;
            g.fat_type = ty;
            g.sector_shift = 4'(sh);
            g.first_data_sector = data_start[35:0];
            g.first_cluster_sector = clus_start[35:0];
            g.cluster_total = clusters[31:0];
            g.last_cluster = 33'(clusters + 64'd1);
            g.root_sector = root_at[39:0];
            g.cluster_mask = (ty == FAT_12) ? MASK12 : (ty == FAT_16) ? MASK16 : MASK32;
            g.volume_sectors = vol[31:0];
        end
        g.status = st;
        return g;
    endfunction

    // Builds a consistent boot sector whose cluster area holds the given cluster count.
    function automatic t_bpb layout_bpb(input int sh, input int csh, input int nfat,
                                        input int nroot, input longint fat_len,
                                        input int resv, input longint clusters);
        t_bpb b;
        longint vol;
        vol = resv + fat_len * nfat
              + ((longint'(nroot) * DIR_ENTRY_BYTES + (1 << sh) - 1) >> sh)
              + (clusters << csh) + $urandom_range((1 << csh) - 1);
        b.bytes_per_sector = 16'(1 << sh);
        b.sectors_per_cluster = 8'(1 << csh);
        b.fat_copies = 8'(nfat);
        b.root_entries = 16'(nroot);
        b.reserved_sectors = 16'(resv);
        b.root_start_cluster = $urandom_range(1000, 2);
        if (vol < 65536 && $urandom_range(1) == 1) begin
            b.total_sectors_short = 16'(vol);
            b.total_sectors_long = $urandom();
        end else begin
            b.total_sectors_short = 16'd0;
            b.total_sectors_long = 32'(vol);
        end
        if (fat_len < 65536 && $urandom_range(1) == 1) begin
            b.fat_size_short = 16'(fat_len);
            b.fat_size_long = $urandom();
        end else begin
            b.fat_size_short = 16'd0;
            b.fat_size_long = 32'(fat_len);
        end
        return b;
    endfunction

    function automatic t_bpb random_boot_sector();
        t_bpb b;
        int roll, kind, lo, hi, nfat, nroot, resv;
        longint clusters, fat_len;
        roll = $urandom_range(99);
        if (roll < 15) begin
            b.bytes_per_sector = 16'($urandom());
            b.sectors_per_cluster = 8'($urandom());
            b.fat_copies = 8'($urandom());
            b.root_entries = 16'($urandom());
            b.total_sectors_short = 16'($urandom());
            b.total_sectors_long = $urandom();
            b.fat_size_short = 16'($urandom());
            b.fat_size_long = $urandom();
            b.reserved_sectors = 16'($urandom());
            b.root_start_cluster = $urandom();
            return b;
        end
        kind = $urandom_range(2);
        case (kind)
            0: begin lo = 0; hi = 4084; end
            1: begin lo = 4085; hi = 65524; end
            default: begin lo = 65525; hi = 1 << 21; end
        endcase
        case ($urandom_range(5))
            0: clusters = lo;
            1: clusters = hi;
            default: clusters = $urandom_range(hi, lo);
        endcase
        nfat = ($urandom_range(3) == 0) ? $urandom_range(8, 1) : 2;
        if (kind == 2) begin
            fat_len = ($urandom_range(7) == 0) ? $urandom_range(1 << 20, 1)
                                               : $urandom_range(20000, 1);
            nroot = ($urandom_range(9) == 0) ? $urandom_range(65535, 1) : 0;
            resv = 32;
        end else begin
            fat_len = ($urandom_range(9) == 0) ? 65535 : $urandom_range(300, 1);
            case ($urandom_range(11))
                0: nroot = 0;
                1, 2, 3: nroot = $urandom_range(65535, 1);
                default: nroot = 16 * $urandom_range(64, 1);
            endcase
            resv = $urandom_range(8, 1);
        end
        if ($urandom_range(9) == 0) resv = $urandom_range(65535, 1);
        b = layout_bpb($urandom_range(12, 9), $urandom_range(7), nfat, nroot, fat_len,
                       resv, clusters);
        if ($urandom_range(7) == 0) b.root_start_cluster = $urandom();
        if (roll < 25) begin
            case ($urandom_range(5))
                0: b.bytes_per_sector = 16'($urandom());
                1: b.sectors_per_cluster = 8'($urandom());
                2: b.fat_copies = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(255, 9));
                3: begin
                    b.fat_size_short = 16'd0;
                    b.fat_size_long = 32'd0;
                end
                4: begin
                    if ($urandom_range(1) == 0) begin
                        b.reserved_sectors = 16'd0;
                    end else begin
                        b.reserved_sectors = 16'hFFFF;
                        b.total_sectors_short = 16'($urandom_range(65534, 1));
                    end
                end
                default: begin
                    b.total_sectors_short = 16'd0;
                    b.total_sectors_long = 32'(b.reserved_sectors) + $urandom_range(2);
                end
            endcase
        end
        return b;
    endfunction

    task automatic load_directed();
        t_bpb base, b;
        base = layout_bpb(9, 0, 1, 16, 1, 1, 10);
        boot_sectors_queued.push_back(base);
        boot_sectors_queued.push_back(layout_bpb(12, 7, 8, 512, 100, 32, 3000));
        boot_sectors_queued.push_back(layout_bpb(9, 0, 2, 512, 200, 1, 4084));
        boot_sectors_queued.push_back(layout_bpb(9, 0, 2, 512, 200, 1, 4085));
        boot_sectors_queued.push_back(layout_bpb(10, 2, 2, 512, 256, 4, 65524));
        b = layout_bpb(9, 3, 2, 0, 2000, 32, 65525);
        b.root_start_cluster = 32'd0;
        boot_sectors_queued.push_back(b);
        b.root_start_cluster = 32'd1;
        boot_sectors_queued.push_back(b);
        b.root_start_cluster = 32'hFFFF_FFFF;
        boot_sectors_queued.push_back(b);
        b.total_sectors_short = 16'd0;
        b.total_sectors_long = 32'hFFFF_FFFF;
        boot_sectors_queued.push_back(b);
        boot_sectors_queued.push_back(layout_bpb(11, 5, 2, 16, 5000, 32, 100000));
        boot_sectors_queued.push_back(layout_bpb(10, 1, 2, 0, 100, 1, 5000));
        b = base; b.bytes_per_sector = 16'd0;      boot_sectors_queued.push_back(b);
        b = base; b.bytes_per_sector = 16'hFFFF;   boot_sectors_queued.push_back(b);
        b = base; b.bytes_per_sector = 16'd513;    boot_sectors_queued.push_back(b);
        b = base; b.sectors_per_cluster = 8'd0;    boot_sectors_queued.push_back(b);
        b = base; b.sectors_per_cluster = 8'd3;    boot_sectors_queued.push_back(b);
        b = base; b.sectors_per_cluster = 8'd255;  boot_sectors_queued.push_back(b);
        b = base; b.fat_copies = 8'd0;             boot_sectors_queued.push_back(b);
        b = base; b.fat_copies = 8'd9;             boot_sectors_queued.push_back(b);
        b = base; b.fat_copies = 8'd255;           boot_sectors_queued.push_back(b);
        b = base;
        b.fat_size_short = 16'd0;
        b.fat_size_long = 32'd0;
        boot_sectors_queued.push_back(b);
        b = base; b.reserved_sectors = 16'd0;      boot_sectors_queued.push_back(b);
        b = base;
        b.reserved_sectors = 16'hFFFF;
        b.total_sectors_short = 16'd100;
        boot_sectors_queued.push_back(b);
        b = base;
        b.total_sectors_short = 16'd0;
        b.total_sectors_long = 32'd2;
        boot_sectors_queued.push_back(b);
        b = base;
        b.total_sectors_short = 16'd0;
        b.total_sectors_long = 32'hFFFF_FFFF;
        b.fat_size_short = 16'd0;
        b.fat_size_long = 32'hFFFF_FFFF;
        b.fat_copies = 8'd8;
        boot_sectors_queued.push_back(b);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [7:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_FORCED_TYPE) forced_mode = data[1:0];
        else if (idx == CFG_BACKUP) backup_mode = data[0];
    endtask

    task automatic wait_drained();
        while (boot_sectors_queued.size() != 0 || i_in_valid || geometry_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic compare_field(input string name, input logic [39:0] want,
                                 input logic [39:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                geometry_due.push_back(decode_geometry(offered, forced_mode, backup_mode));
            if (!i_in_valid || !o_in_stall) begin
                if (boot_sectors_queued.size() != 0
                    && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
                    offered = boot_sectors_queued.pop_front();
                    i_bytes_per_sector <= offered.bytes_per_sector;
                    i_sectors_per_cluster <= offered.sectors_per_cluster;
                    i_fat_copies <= offered.fat_copies;
                    i_root_entries <= offered.root_entries;
                    i_total_sectors_short <= offered.total_sectors_short;
                    i_total_sectors_long <= offered.total_sectors_long;
                    i_fat_size_short <= offered.fat_size_short;
                    i_fat_size_long <= offered.fat_size_long;
                    i_reserved_sectors <= offered.reserved_sectors;
                    i_root_start_cluster <= offered.root_start_cluster;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (geometry_due.size() == 0) begin
                    $display("%0t: result transaction with status %0d but none expected",
                             $time, o_status);
                    mismatches++;
                end else begin
                    want_geom = geometry_due.pop_front();
                    compare_field("status", want_geom.status, o_status);
                    compare_field("fat_type", want_geom.fat_type, o_fat_type);
                    compare_field("sector_shift", want_geom.sector_shift, o_sector_shift);
                    compare_field("first_data_sector", want_geom.first_data_sector,
                                  o_first_data_sector);
                    compare_field("first_cluster_sector", want_geom.first_cluster_sector,
                                  o_first_cluster_sector);
                    compare_field("cluster_total", want_geom.cluster_total, o_cluster_total);
                    compare_field("last_cluster", want_geom.last_cluster, o_last_cluster);
                    compare_field("root_sector", want_geom.root_sector, o_root_sector);
                    compare_field("cluster_mask", want_geom.cluster_mask, o_cluster_mask);
                    compare_field("volume_sectors", want_geom.volume_sectors,
                                  o_volume_sectors);
                    results_checked++;
                    if (want_geom.status == ST_OK) decoded_ok++;
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    initial begin
        logic [1:0] forced_plan [PHASES] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd0, 2'd1, 2'd2};
        logic       backup_plan [PHASES] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
        int phase, n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (phase = 0; phase < PHASES; phase++) begin
            write_reg(CFG_FORCED_TYPE, 8'({$urandom(), forced_plan[phase]}));
            write_reg(CFG_BACKUP, 8'({$urandom(), backup_plan[phase]}));
            if (phase == 4) write_reg(CFG_SPARE, 8'($urandom()));
            i_cfg_valid <= 1'b0;
            steady <= (phase == 2);
            if (phase == 1) hold_requests <= hold_requests + 1;
            if (phase == 0) load_directed();
            for (n = 0; n < RANDOM_PER_PHASE; n++)
                boot_sectors_queued.push_back(random_boot_sector());
            wait_drained();
        end
        $display("Checked %0d geometry results over %0d register settings, %0d without error.",
                 results_checked, PHASES, decoded_ok);
        $display("Covered corner cases, all FAT types, corrupted and random sectors, stalls.");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* fat_boot_sector_geometry_decoder.f */
design/fbsg_pkg.sv
design/fbsg_calc.sv
design/fat_boot_sector_geometry_decoder.sv
tb/fat_boot_sector_geometry_decoder_test.sv
